[rtl/mdvf_pkg.sv]
`timescale 1ns / 1ps
// mdvf_pkg: shared types, constants and codes for the median depth/velocity filter
// depends on nothing

package mdvf_pkg;

    localparam int MAX_WINDOW_DEF = 8;
    localparam int MAX_SPAN_DEF   = 16;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_ZERO   = 2'd2;

    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_SPAN   = 2'd1;
    localparam logic [1:0] REG_SCALE  = 2'd2;
    localparam logic [1:0] REG_STALE  = 2'd3;

    localparam logic [23:0] ZERO_RESET = 24'd65536;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT,
        S_DEPTH,
        S_HREAD,
        S_HWAIT,
        S_DIVSET,
        S_DIV,
        S_FINISH,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic do_sample;
        logic do_zero;
        logic sort_init;
        logic sort_step;
        logic depth_calc;
        logic hist_read;
        logic div_init;
        logic div_step;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic has_sample;
        logic sort_done;
        logic div_needed;
        logic div_done;
        logic fresh;
    } t_status;

endpackage

[rtl/mdvf_ctrl.sv]
`timescale 1ns / 1ps
// mdvf_ctrl: sequencer for sample, tick and zero-set requests
// depends on mdvf_pkg

module mdvf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_in_cmd,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic                o_kind,
    output mdvf_pkg::t_cmd      o_cmd,
    input  mdvf_pkg::t_status   i_status
);
    import mdvf_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_kind      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_kind      <= n_kind;
        end
    end

    logic out_free;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                // ticks and zero-sets overwrite the result registers, samples never do
                o_in_ready = (i_in_cmd == CMD_SAMPLE) || out_free;
                if (i_in_valid && o_in_ready) begin
                    case (i_in_cmd)
                        CMD_SAMPLE: o_cmd.do_sample = 1'b1;
                        CMD_ZERO: begin
                            o_cmd.do_zero = 1'b1;
                            n_out_valid   = 1'b1;
                            n_kind        = 1'b1;
                        end
                        CMD_TICK: begin
                            if (i_status.has_sample) begin
                                o_cmd.sort_init = 1'b1;
                                n_state         = S_SORT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SORT: begin
                o_cmd.sort_step = 1'b1;
                if (i_status.sort_done) n_state = S_DEPTH;
            end
            S_DEPTH: begin
                o_cmd.depth_calc = 1'b1;
                n_state          = S_HREAD;
            end
            S_HREAD: begin
                o_cmd.hist_read = 1'b1;
                n_state         = S_HWAIT;
            end
            S_HWAIT: n_state = S_DIVSET;
            S_DIVSET: begin
                if (i_status.div_needed) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = i_status.fresh ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;

endmodule

[rtl/mdvf_dp.sv]
`timescale 1ns / 1ps
// mdvf_dp: sample ring, median sort, depth scaling, history memory and divider
// depends on mdvf_pkg

module mdvf_dp #(
    parameter int MAX_WINDOW = mdvf_pkg::MAX_WINDOW_DEF,
    parameter int MAX_SPAN   = mdvf_pkg::MAX_SPAN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic [23:0]        i_pressure,
    input  logic [31:0]        i_stamp_ms,
    input  mdvf_pkg::t_cmd     i_cmd,
    output mdvf_pkg::t_status  o_status,
    output logic signed [31:0] o_depth,
    output logic signed [31:0] o_velocity,
    output logic               o_success
);
    import mdvf_pkg::*;

    localparam int WB = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WC = $clog2(MAX_WINDOW + 1);
    localparam int SB = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
    localparam int SC = $clog2(MAX_SPAN + 1);

    // ring slot that lies back places behind the newest one
    function automatic logic [WB-1:0] ring_pos(logic [WB-1:0] head, int back);
        int k;
        k = int'(head) - 1 - back;
        if (k < 0) k = k + MAX_WINDOW;
        return WB'(k);
    endfunction

    // registers
    logic [3:0]  r_window;
    logic [4:0]  r_span;
    logic [15:0] r_scale;
    logic [15:0] r_stale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= 4'd3;
            r_span   <= 5'd5;
            r_scale  <= 16'd2560;
            r_stale  <= 16'd1000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WINDOW: r_window <= i_cfg_data[3:0];
                REG_SPAN:   r_span   <= i_cfg_data[4:0];
                REG_SCALE:  r_scale  <= i_cfg_data[15:0];
                REG_STALE:  r_stale  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [WC-1:0] eff_w;
    logic [SC-1:0] eff_s;
    always_comb begin
        if (r_window == 4'd0) eff_w = WC'(1);
        else if (32'(r_window) > MAX_WINDOW) eff_w = WC'(MAX_WINDOW);
        else eff_w = WC'(r_window);
        if (r_span == 5'd0) eff_s = SC'(1);
        else if (32'(r_span) > MAX_SPAN) eff_s = SC'(MAX_SPAN);
        else eff_s = SC'(r_span);
    end

    // sample ring, read at fixed places
    logic [23:0]   r_ring [MAX_WINDOW];
    logic [WC-1:0] r_count;
    logic [WB-1:0] r_head;
    logic [31:0]   r_latest;
    logic [23:0]   r_zero;
    logic          r_success;
    logic [WB-1:0] newest_idx;

    assign newest_idx = ring_pos(r_head, 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_head    <= '0;
            r_latest  <= '0;
            r_zero    <= ZERO_RESET;
            r_success <= 1'b0;
        end else begin
            if (i_cmd.do_sample) begin
                r_head   <= (32'(r_head) == MAX_WINDOW - 1) ? '0 : r_head + WB'(1);
                r_count  <= (r_count + WC'(1) > eff_w) ? eff_w : r_count + WC'(1);
                r_latest <= i_stamp_ms;
            end
            if (i_cmd.do_zero) begin
                r_success <= (r_count != '0);
                if (r_count != '0) r_zero <= r_ring[newest_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_sample) r_ring[r_head] <= i_pressure;
    end

    // odd-even transposition sort over the window, invalid slots hold max
    logic [24:0]   r_buf [MAX_WINDOW];
    logic [WC-1:0] r_n;
    logic [WC:0]   r_pass;
    logic          r_phase;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sort_init) begin
            r_n     <= (r_count < eff_w) ? r_count : eff_w;
            r_pass  <= '0;
            r_phase <= 1'b0;
            for (int i = 0; i < MAX_WINDOW; i++) begin
                if (i < int'((r_count < eff_w) ? r_count : eff_w))
                    r_buf[i] <= {1'b0, r_ring[ring_pos(r_head, i)]};
                else
                    r_buf[i] <= {1'b1, 24'd0};
            end
        end else if (i_cmd.sort_step) begin
            r_pass  <= r_pass + 1'b1;
            r_phase <= ~r_phase;
            for (int i = 0; i + 1 < MAX_WINDOW; i++) begin
                if ((i % 2) == int'(r_phase) && r_buf[i] > r_buf[i + 1]) begin
                    r_buf[i]     <= r_buf[i + 1];
                    r_buf[i + 1] <= r_buf[i];
                end
            end
        end
    end

    assign o_status.sort_done = (32'(r_pass) >= MAX_WINDOW - 1);

    logic [23:0] med;
    assign med = r_buf[WB'(r_n >> 1)][23:0];

    // depth: (med - zero) * scale, round and floor by 256, saturate
    logic signed [31:0] r_depth;
    logic signed [24:0] pdiff;
    logic signed [41:0] prod;
    logic signed [33:0] dsh;
    assign pdiff = $signed({1'b0, med}) - $signed({1'b0, r_zero});
    assign prod  = 42'(pdiff) * $signed({1'b0, r_scale}) + 42'sd128;
    assign dsh   = 34'(prod >>> 8);

    always_ff @(posedge i_clk) begin
        if (i_cmd.depth_calc) begin
            if (dsh > 34'sh07FFFFFFF) r_depth <= 32'sh7FFFFFFF;
            else if (dsh < -34'sh080000000) r_depth <= 32'sh80000000;
            else r_depth <= 32'(dsh);
        end
    end

    // history memory
    logic [63:0]   r_hmem [MAX_SPAN];
    logic [63:0]   r_hrd;
    logic [SC-1:0] r_hcount;
    logic [SB-1:0] r_hhead;
    logic [SC-1:0] hn;
    logic [SB-1:0] old_idx;
    assign hn      = (r_hcount < eff_s) ? r_hcount : eff_s;
    assign old_idx = (32'(r_hhead) >= 32'(hn)) ? SB'(32'(r_hhead) - 32'(hn))
                                               : SB'(32'(r_hhead) + MAX_SPAN - 32'(hn));

    always_ff @(posedge i_clk) begin
        if (i_cmd.hist_read) r_hrd <= r_hmem[old_idx];
        if (i_cmd.finish) r_hmem[r_hhead] <= {r_latest, r_depth};
    end

    // velocity divider: q = (2an + ad) / (2ad), restoring, one bit a cycle
    localparam int NB = 53;
    logic [NB-1:0] r_num;
    logic [33:0]   r_den;
    logic [34:0]   r_rem;
    logic [5:0]    r_bit;
    logic          r_neg;
    logic          r_dnz;
    logic signed [31:0] r_vel;

    logic signed [32:0] dtv;
    logic signed [32:0] ddv;
    logic signed [43:0] numv;
    logic [43:0]        an;
    logic [31:0]        ad;
    assign dtv  = 33'($signed(r_latest - r_hrd[63:32]));
    assign ddv  = 33'(r_depth) - 33'($signed(r_hrd[31:0]));
    assign numv = 44'(ddv) * 44'sd1000;
    assign an   = numv[43] ? 44'(-numv) : 44'(numv);
    assign ad   = dtv[32] ? 32'(-dtv) : 32'(dtv);

    assign o_status.div_needed = (hn != '0) && (dtv != '0);

    logic [34:0] trial;
    assign trial = {r_rem[33:0], r_num[NB-1]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel    <= '0;
            r_hcount <= '0;
            r_hhead  <= '0;
        end else begin
            if (i_cmd.div_init) begin
                r_num <= NB'({an, 1'b0}) + NB'(ad);
                r_den <= {1'b0, ad, 1'b0};
                r_rem <= '0;
                r_bit <= '0;
                r_neg <= numv[43] ^ dtv[32];
                r_dnz <= 1'b1;
            end else if (i_cmd.div_step) begin
                r_num <= {r_num[NB-2:0], ~trial[34]};
                r_rem <= trial[34] ? {r_rem[33:0], r_num[NB-1]} : trial;
                r_bit <= r_bit + 6'd1;
            end
            if (i_cmd.finish) begin
                r_hhead  <= (32'(r_hhead) == MAX_SPAN - 1) ? '0 : r_hhead + SB'(1);
                r_hcount <= (r_hcount + SC'(1) > eff_s) ? eff_s : r_hcount + SC'(1);
                if (r_dnz) begin
                    if (!r_neg && r_num > NB'(32'h7FFFFFFF)) r_vel <= 32'sh7FFFFFFF;
                    else if (r_neg && r_num > NB'(33'h080000000)) r_vel <= 32'sh80000000;
                    else r_vel <= r_neg ? 32'(-$signed({1'b0, r_num})) : 32'(r_num);
                end
            end
            if (i_cmd.sort_init) r_dnz <= 1'b0;
        end
    end

    assign o_status.div_done = (r_bit == 6'(NB - 1));

    logic [31:0] r_tick_stamp;
    always_ff @(posedge i_clk) begin
        if (i_cmd.sort_init) r_tick_stamp <= i_stamp_ms;
    end
    logic signed [31:0] tage;
    assign tage = $signed(r_tick_stamp - r_latest);
    assign o_status.fresh = tage < $signed({16'd0, r_stale});

    assign o_status.has_sample = (r_count != '0);
    assign o_depth    = r_depth;
    assign o_velocity = r_vel;
    assign o_success  = r_success;

endmodule

[rtl/median_depth_velocity_filter_core.sv]
`timescale 1ns / 1ps
// median_depth_velocity_filter_core: top level of the median depth/velocity filter
// depends on mdvf_pkg, mdvf_ctrl, mdvf_dp
//
// channel  dir  handshake                 payload
// s_axis   in   s_axis_tvalid/tready      tuser cmd, tdata pressure and stamp
// m_axis   out  m_axis_tvalid/tready      tuser kind/success, tdata depth and velocity
// cfg      in   i_cfg_valid/o_cfg_ready   register index and write data
//
// a sample request is taken while idle, a zero-set only when the output slot is also free
// a tick sorts the window, scales the depth, reads the history and then runs the velocity
// divider when it is needed (one quotient bit per cycle)
// reset clears the counts and velocity and sets the zero pressure to 65536; the stores need no clearing
// a held result stalls ticks and zero-set requests, samples still pass

module median_depth_velocity_filter_core #(
    parameter int MAX_WINDOW = mdvf_pkg::MAX_WINDOW_DEF,
    parameter int MAX_SPAN   = mdvf_pkg::MAX_SPAN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // pressure[23:0], stamp_ms[55:24]
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // depth_out[31:0], velocity_out[63:32]
    output logic [1:0]  m_axis_tuser,   // kind[0], success[1]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import mdvf_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    kind;
    logic signed [31:0] depth, vel;
    logic    success;

    mdvf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_cmd    (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_kind      (kind),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    mdvf_dp #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_SPAN   (MAX_SPAN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pressure  (s_axis_tdata[23:0]),
        .i_stamp_ms  (s_axis_tdata[55:24]),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_depth     (depth),
        .o_velocity  (vel),
        .o_success   (success)
    );

    // acknowledgement carries zero depth and velocity, report carries no success
    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = kind ? 64'd0 : {vel, depth};
    assign m_axis_tuser = {kind & success, kind};

endmodule
